// File: rtl/hbp_pkg.sv
// hbp_pkg: shared constants, codes and types of the huffman bit packer
// no dependencies; every file of the block but hbp_ram uses it by scoped names
`timescale 1ns / 1ps

package hbp_pkg;

  localparam int WORD_BITS     = 64;
  localparam int SAMPLE_BITS   = 12;
  localparam int MAX_CODE_BITS = 32;

  // fixed field widths of the channels
  localparam int KIND_W      = 2;
  localparam int CODE_FIELD_W = 32;
  localparam int LEN_FIELD_W  = 6;
  localparam int TOTAL_W      = 32;

  // derived widths
  localparam int LEN_W       = $clog2(MAX_CODE_BITS + 1);
  localparam int TABLE_DEPTH = 1 << SAMPLE_BITS;
  localparam int ENTRY_W     = MAX_CODE_BITS + LEN_W;
  localparam int POS_W       = $clog2(WORD_BITS);
  localparam int SUM_W       = $clog2(WORD_BITS + MAX_CODE_BITS);
  localparam int WIDE_W      = WORD_BITS + MAX_CODE_BITS;

  // queue between lookup and packer
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_t;

  typedef struct packed {
    logic                     flush;
    logic [MAX_CODE_BITS-1:0] code;
    logic [LEN_W-1:0]         len;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

endpackage

// File: rtl/hbp_if.sv
// hbp_if: request and result channel interfaces of the huffman bit packer
// depends on hbp_pkg for field widths
`timescale 1ns / 1ps

interface hbp_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [hbp_pkg::KIND_W-1:0]             kind;
  logic [hbp_pkg::SAMPLE_BITS-1:0]        sample;
  logic [hbp_pkg::CODE_FIELD_W-1:0]       code_bits;
  logic [hbp_pkg::LEN_FIELD_W-1:0]        code_length;

  modport source (output valid, kind, sample, code_bits, code_length, input ready);
  modport sink   (input valid, kind, sample, code_bits, code_length, output ready);
endinterface

interface hbp_out_if;
  logic                            valid;
  logic                            ready;
  logic [hbp_pkg::WORD_BITS-1:0]   packed_word;
  logic [hbp_pkg::TOTAL_W-1:0]     total_bits;
  logic                            last;

  modport source (output valid, packed_word, total_bits, last, input ready);
  modport sink   (input valid, packed_word, total_bits, last, output ready);
endinterface

// File: rtl/huffman_bit_packer_top.sv
// huffman_bit_packer_top: variable-length code packer, lsb first, 64-bit words
// depends on hbp_pkg, hbp_if, hbp_front, hbp_queue and hbp_pack
//
//   channel   dir   handshake          payload
//   in_ch     in    valid / ready      kind, sample, code_bits, code_length
//   out_ch    out   valid / ready      packed_word, total_bits, last
//
// one request per cycle sustained while the queue has room; a word or flush result is offered
// after its request is accepted through the table read register, a queue slot and the output register
// the code table ram read and the single shift-and-or packer set the pace
// rst_n is synchronous; table contents are not cleared and need no sweep
// a stalled result is held while up to four looked-up requests queue behind it
`timescale 1ns / 1ps

module huffman_bit_packer_top (
  input  logic      clk,
  input  logic      rst_n,
  hbp_in_if.sink    in_ch,
  hbp_out_if.source out_ch
);

  hbp_pkg::q_push_t   q_push;
  hbp_pkg::q_status_t q_stat;
  hbp_pkg::q_entry_t  head;
  logic               pop;

  hbp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_push (q_push)
  );

  hbp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  hbp_pack u_pack (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_stat.empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

  // a lookup in flight always finds room in the queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.valid |-> (q_stat.count < hbp_pkg::QCNT_W'(hbp_pkg::QDEPTH) || pop))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // completed words carry no block total
  a_total_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last) |-> (out_ch.total_bits == '0))
    else $error("total on non-final word");

endmodule

// File: rtl/hbp_ram.sv
// hbp_ram: generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module hbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/hbp_front.sv
// hbp_front: accepts requests, writes code table loads, looks up encodes, marks flushes
// depends on hbp_pkg, hbp_if and hbp_ram; feeds the queue in the cycle after accept
`timescale 1ns / 1ps

module hbp_front (
  input  logic                clk,
  input  logic                rst_n,
  hbp_in_if.sink              in_ch,
  input  hbp_pkg::q_status_t  q_stat,
  output hbp_pkg::q_push_t    q_push
);

  logic                              accept;
  hbp_pkg::kind_t                    kind;
  logic                              tbl_wr;
  logic [hbp_pkg::LEN_W-1:0]         ld_len;
  logic [hbp_pkg::MAX_CODE_BITS-1:0] ld_code;
  logic [hbp_pkg::ENTRY_W-1:0]       rd_entry;
  logic                              s1_valid_r, s1_valid_nxt;
  logic                              s1_flush_r, s1_flush_nxt;

  // room for the in-flight lookup plus this request
  assign in_ch.ready = ({1'b0, q_stat.count} + (hbp_pkg::QCNT_W + 1)'(s1_valid_r)) <
                       (hbp_pkg::QCNT_W + 1)'(hbp_pkg::QDEPTH);
  assign accept = in_ch.valid && in_ch.ready;
  assign kind   = hbp_pkg::kind_t'(in_ch.kind);

  always_comb begin
    tbl_wr       = 1'b0;
    s1_valid_nxt = 1'b0;
    s1_flush_nxt = 1'b0;
    if (accept) begin
      unique case (kind)
        hbp_pkg::KIND_LOAD:   tbl_wr = 1'b1;
        hbp_pkg::KIND_ENCODE: s1_valid_nxt = 1'b1;
        hbp_pkg::KIND_FLUSH: begin
          s1_valid_nxt = 1'b1;
          s1_flush_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // clamp overlong lengths and drop stray bits above the length
  always_comb begin
    if (in_ch.code_length > hbp_pkg::LEN_FIELD_W'(hbp_pkg::MAX_CODE_BITS)) begin
      ld_len = hbp_pkg::LEN_W'(hbp_pkg::MAX_CODE_BITS);
    end else begin
      ld_len = in_ch.code_length[hbp_pkg::LEN_W-1:0];
    end
    for (int i = 0; i < hbp_pkg::MAX_CODE_BITS; i++) begin
      ld_code[i] = in_ch.code_bits[i] && (hbp_pkg::LEN_W'(i) < ld_len);
    end
  end

  hbp_ram #(
    .WIDTH (hbp_pkg::ENTRY_W),
    .DEPTH (hbp_pkg::TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (in_ch.sample),
    .wr_data ({ld_code, ld_len}),
    .rd_addr (in_ch.sample),
    .rd_data (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_flush_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s1_flush_r <= s1_flush_nxt;
    end
  end

  always_comb begin
    q_push.valid       = s1_valid_r;
    q_push.entry.flush = s1_flush_r;
    q_push.entry.code  = rd_entry[hbp_pkg::ENTRY_W-1:hbp_pkg::LEN_W];
    q_push.entry.len   = rd_entry[hbp_pkg::LEN_W-1:0];
  end

endmodule

// File: rtl/hbp_queue.sv
// hbp_queue: short fifo of looked-up codes and flush marks
// depends on hbp_pkg; sits between hbp_front and hbp_pack
`timescale 1ns / 1ps

module hbp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  hbp_pkg::q_push_t    q_push,
  input  logic                pop,
  output hbp_pkg::q_entry_t   head,
  output hbp_pkg::q_status_t  q_stat
);

  hbp_pkg::q_entry_t                slots_r [hbp_pkg::QDEPTH];
  logic [hbp_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [hbp_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [hbp_pkg::QCNT_W-1:0]       count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_push.valid) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    unique case ({q_push.valid, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.valid) begin
      slots_r[wr_ptr_r] <= q_push.entry;
    end
  end

  assign head         = slots_r[rd_ptr_r];
  assign q_stat.count = count_r;
  assign q_stat.empty = (count_r == '0);

endmodule

// File: rtl/hbp_pack.sv
// hbp_pack: lsb-first bit accumulator, word emission and block flush
// depends on hbp_pkg and hbp_if; drains hbp_queue into the registered result stage
`timescale 1ns / 1ps

module hbp_pack (
  input  logic                clk,
  input  logic                rst_n,
  input  hbp_pkg::q_entry_t   head,
  input  logic                q_empty,
  output logic                pop,
  hbp_out_if.source           out_ch
);

  logic [hbp_pkg::WORD_BITS-1:0] acc_r, acc_nxt;
  logic [hbp_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [hbp_pkg::TOTAL_W-1:0]   total_r, total_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [hbp_pkg::WORD_BITS-1:0] word_r, word_nxt;
  logic [hbp_pkg::TOTAL_W-1:0]   tbits_r, tbits_nxt;
  logic                          last_r, last_nxt;

  logic [hbp_pkg::WIDE_W-1:0]    wide;
  logic [hbp_pkg::WORD_BITS-1:0] acc_or;
  logic [hbp_pkg::SUM_W-1:0]     pos_sum;
  logic                          fill;
  logic [hbp_pkg::TOTAL_W:0]     tsum;

  assign pop = !q_empty && (!out_valid_r || out_ch.ready);

  always_comb begin
    wide    = hbp_pkg::WIDE_W'(head.code) << pos_r;
    acc_or  = acc_r | wide[hbp_pkg::WORD_BITS-1:0];
    pos_sum = hbp_pkg::SUM_W'(pos_r) + hbp_pkg::SUM_W'(head.len);
    fill    = pos_sum >= hbp_pkg::SUM_W'(hbp_pkg::WORD_BITS);
    tsum    = {1'b0, total_r} + (hbp_pkg::TOTAL_W + 1)'(head.len);
  end

  always_comb begin
    acc_nxt       = acc_r;
    pos_nxt       = pos_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    word_nxt      = word_r;
    tbits_nxt     = tbits_r;
    last_nxt      = last_r;
    if (pop) begin
      if (head.flush) begin
        out_valid_nxt = 1'b1;
        word_nxt      = acc_r;
        tbits_nxt     = total_r;
        last_nxt      = 1'b1;
        acc_nxt       = '0;
        pos_nxt       = '0;
        total_nxt     = '0;
      end else begin
        // saturating block total
        total_nxt = tsum[hbp_pkg::TOTAL_W] ? '1 : tsum[hbp_pkg::TOTAL_W-1:0];
        if (fill) begin
          out_valid_nxt = 1'b1;
          word_nxt      = acc_or;
          tbits_nxt     = '0;
          last_nxt      = 1'b0;
          // spilled high bits open the next word
          acc_nxt = hbp_pkg::WORD_BITS'(wide[hbp_pkg::WIDE_W-1:hbp_pkg::WORD_BITS]);
          pos_nxt = hbp_pkg::POS_W'(pos_sum - hbp_pkg::SUM_W'(hbp_pkg::WORD_BITS));
        end else begin
          acc_nxt = acc_or;
          pos_nxt = pos_sum[hbp_pkg::POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      pos_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      pos_r       <= pos_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r  <= word_nxt;
    tbits_r <= tbits_nxt;
    last_r  <= last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.packed_word = word_r;
  assign out_ch.total_bits  = tbits_r;
  assign out_ch.last        = last_r;

endmodule
